### rtl/core/serial_console_line_editor_unit_assert.svh
// ----------------------------------------------------------------------------
// Serial console line editor assertion macros
// Shared property forms for the line editor modules.
// ----------------------------------------------------------------------------
`ifndef SERIAL_CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH
`define SERIAL_CONSOLE_LINE_EDITOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCE_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/sce_pkg.sv
// ----------------------------------------------------------------------------
// Serial console line editor package
// Types, constants and codes shared by the line editor modules.
// ----------------------------------------------------------------------------
package sce_pkg;

  localparam int LINE_DEPTH = 32;
  localparam int ADDR_W = $clog2(LINE_DEPTH);
  localparam int CNT_W = $clog2(LINE_DEPTH + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] BREAK_BYTE = 8'd3;
  localparam logic [7:0] ESC_BYTE = 8'd27;
  localparam logic [7:0] BRACKET_BYTE = 8'd91;
  localparam logic [7:0] UP_BYTE = 8'd65;
  localparam logic [7:0] DOWN_BYTE = 8'd66;

  localparam logic [7:0] CFG_NEWLINE = 8'd0;
  localparam logic [7:0] CFG_ERASE = 8'd1;
  localparam logic [7:0] CFG_CURSOR_BACK = 8'd2;
  localparam logic [7:0] CFG_BLANK = 8'd3;

  localparam logic [7:0] RST_NEWLINE = 8'd13;
  localparam logic [7:0] RST_ERASE = 8'd8;
  localparam logic [7:0] RST_CURSOR_BACK = 8'd8;
  localparam logic [7:0] RST_BLANK = 8'd32;

  typedef enum logic [2:0] {
    KIND_ECHO   = 3'd0,
    KIND_CMD    = 3'd1,
    KIND_END    = 3'd2,
    KIND_FULL   = 3'd3,
    KIND_CANCEL = 3'd4,
    KIND_UP     = 3'd5,
    KIND_DOWN   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    OP_STORE,
    OP_LINE,
    OP_ERASE,
    OP_CANCEL,
    OP_UP,
    OP_DOWN,
    OP_FULL
  } cmd_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERASE1,
    ST_ERASE2,
    ST_FETCH,
    ST_PLAY,
    ST_END
  } back_state_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [7:0]       data;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic [7:0] newline;
    logic [7:0] erase;
    logic [7:0] cursor_back;
    logic [7:0] blank;
  } cfg_regs_t;

endpackage

### rtl/core/sce_front.sv
// ----------------------------------------------------------------------------
// Line editor front end
// Accepts received bytes, tracks the line fill and escape state, and queues
// one command for each byte that gives results.
// ----------------------------------------------------------------------------
module sce_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              rx_byte,
  input  logic                    iterative_running,
  input  sce_pkg::cfg_regs_t      cfg,
  input  logic                    q_full,
  output logic                    push,
  output sce_pkg::cmd_t           push_cmd
);

  logic [sce_pkg::CNT_W-1:0] fill;
  logic [sce_pkg::CNT_W-1:0] fill_next;
  logic                      esc;
  logic                      esc_next;
  logic                      brk;
  logic                      brk_next;
  logic                      accept;
  logic                      has_cmd;
  logic                      esc_a;
  logic                      brk_a;

  assign in_stall = q_full;
  assign accept = in_valid && !q_full;
  assign push = accept && has_cmd;

  always_comb begin
    esc_a = esc;
    brk_a = brk;
    if (esc && !brk && rx_byte != sce_pkg::BRACKET_BYTE) begin
      esc_a = 1'b0;
      brk_a = 1'b0;
    end
    if (esc && brk && rx_byte != sce_pkg::UP_BYTE && rx_byte != sce_pkg::DOWN_BYTE) begin
      esc_a = 1'b0;
      brk_a = 1'b0;
    end

    fill_next = fill;
    esc_next = esc_a;
    brk_next = brk_a;
    has_cmd = 1'b0;
    push_cmd.op = sce_pkg::OP_STORE;
    push_cmd.data = rx_byte;
    push_cmd.cnt = fill;

    priority if (fill >= sce_pkg::CNT_W'(sce_pkg::LINE_DEPTH - 1) && rx_byte != cfg.erase) begin
      has_cmd = 1'b1;
      push_cmd.op = sce_pkg::OP_FULL;
    end else if (rx_byte == cfg.newline) begin
      has_cmd = 1'b1;
      push_cmd.op = sce_pkg::OP_LINE;
      fill_next = '0;
    end else if (rx_byte == cfg.erase) begin
      if (fill != '0) begin
        has_cmd = 1'b1;
        push_cmd.op = sce_pkg::OP_ERASE;
        fill_next = fill - sce_pkg::CNT_W'(1);
      end
    end else if (rx_byte == sce_pkg::BREAK_BYTE) begin
      has_cmd = iterative_running;
      push_cmd.op = sce_pkg::OP_CANCEL;
    end else if (rx_byte == sce_pkg::ESC_BYTE) begin
      esc_next = 1'b1;
    end else if (esc_a && rx_byte == sce_pkg::BRACKET_BYTE) begin
      brk_next = 1'b1;
    end else if (esc_a && brk_a) begin
      has_cmd = 1'b1;
      push_cmd.op = (rx_byte == sce_pkg::UP_BYTE) ? sce_pkg::OP_UP : sce_pkg::OP_DOWN;
      esc_next = 1'b0;
      brk_next = 1'b0;
    end else begin
      has_cmd = 1'b1;
      push_cmd.op = sce_pkg::OP_STORE;
      fill_next = fill + sce_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      esc <= 1'b0;
      brk <= 1'b0;
    end else if (accept) begin
      fill <= fill_next;
      esc <= esc_next;
      brk <= brk_next;
    end
  end

`include "serial_console_line_editor_unit_assert.svh"

`SCE_ASSERT_IMPLY(a_bracket_needs_escape, brk, esc, "bracket flag set without escape flag")
`SCE_ASSERT_IMPLY(a_fill_in_range, 1'b1, fill <= sce_pkg::CNT_W'(sce_pkg::LINE_DEPTH - 1), "fill count out of range")
`SCE_ASSERT_IMPLY(a_push_on_transfer, push, in_valid && !q_full, "command queued without a transfer")

endmodule

### rtl/core/sce_queue.sv
// ----------------------------------------------------------------------------
// Line editor command queue
// Short FIFO of commands between the front end and the back end.
// ----------------------------------------------------------------------------
module sce_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sce_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          q_valid,
  output sce_pkg::cmd_t q_head,
  input  logic          pop
);

  sce_pkg::cmd_t              entries [sce_pkg::QUEUE_DEPTH];
  logic [sce_pkg::QPTR_W-1:0] wr_ptr;
  logic [sce_pkg::QPTR_W-1:0] rd_ptr;
  logic [sce_pkg::QCNT_W-1:0] count;

  assign full = (count == sce_pkg::QCNT_W'(sce_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sce_pkg::QPTR_W'(sce_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  wr_ptr + sce_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sce_pkg::QPTR_W'(sce_pkg::QUEUE_DEPTH - 1)) ? '0 :
                  rd_ptr + sce_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + sce_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - sce_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

### rtl/core/sce_back.sv
// ----------------------------------------------------------------------------
// Line editor back end
// Executes queued commands, holds the line store and drives the result
// register.
// ----------------------------------------------------------------------------
module sce_back (
  input  logic               clk,
  input  logic               rst,
  input  sce_pkg::cfg_regs_t cfg,
  input  logic               q_valid,
  input  sce_pkg::cmd_t      q_head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         kind,
  output logic [7:0]         data_byte,
  output logic               run_last
);

  logic [7:0]                 line_mem [sce_pkg::LINE_DEPTH];
  logic [7:0]                 rd_data;
  sce_pkg::back_state_t       state;
  sce_pkg::back_state_t       state_next;
  logic [sce_pkg::CNT_W-1:0]  ptr;
  logic [sce_pkg::CNT_W-1:0]  ptr_next;
  logic [sce_pkg::CNT_W-1:0]  len;
  logic [sce_pkg::CNT_W-1:0]  len_next;
  logic                       wr_en;
  logic                       can_load;
  logic                       load;
  sce_pkg::kind_t             ld_kind;
  logic [7:0]                 ld_data;
  logic                       ld_last;
  sce_pkg::kind_t             o_kind;
  logic                       o_valid;
  logic                       o_last;
  logic [7:0]                 o_data;

  assign can_load = !o_valid || !out_stall;
  assign out_valid = o_valid;
  assign kind = o_kind;
  assign data_byte = o_data;
  assign run_last = o_last;

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    len_next = len;
    pop = 1'b0;
    wr_en = 1'b0;
    load = 1'b0;
    ld_kind = sce_pkg::KIND_ECHO;
    ld_data = '0;
    ld_last = 1'b0;
    unique case (state)
      sce_pkg::ST_IDLE: begin
        if (q_valid && can_load) begin
          pop = 1'b1;
          unique case (q_head.op)
            sce_pkg::OP_STORE: begin
              wr_en = 1'b1;
              load = 1'b1;
              ld_data = q_head.data;
              ld_last = 1'b1;
            end
            sce_pkg::OP_LINE: begin
              len_next = q_head.cnt;
              ptr_next = '0;
              if (q_head.cnt == '0) begin
                load = 1'b1;
                ld_kind = sce_pkg::KIND_END;
                ld_last = 1'b1;
              end else begin
                state_next = sce_pkg::ST_FETCH;
              end
            end
            sce_pkg::OP_ERASE: begin
              load = 1'b1;
              ld_data = cfg.cursor_back;
              state_next = sce_pkg::ST_ERASE1;
            end
            sce_pkg::OP_CANCEL: begin
              load = 1'b1;
              ld_kind = sce_pkg::KIND_CANCEL;
              ld_last = 1'b1;
            end
            sce_pkg::OP_UP: begin
              load = 1'b1;
              ld_kind = sce_pkg::KIND_UP;
              ld_last = 1'b1;
            end
            sce_pkg::OP_DOWN: begin
              load = 1'b1;
              ld_kind = sce_pkg::KIND_DOWN;
              ld_last = 1'b1;
            end
            sce_pkg::OP_FULL: begin
              load = 1'b1;
              ld_kind = sce_pkg::KIND_FULL;
              ld_last = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      sce_pkg::ST_ERASE1: begin
        if (can_load) begin
          load = 1'b1;
          ld_data = cfg.blank;
          state_next = sce_pkg::ST_ERASE2;
        end
      end
      sce_pkg::ST_ERASE2: begin
        if (can_load) begin
          load = 1'b1;
          ld_data = cfg.cursor_back;
          ld_last = 1'b1;
          state_next = sce_pkg::ST_IDLE;
        end
      end
      sce_pkg::ST_FETCH: begin
        state_next = sce_pkg::ST_PLAY;
      end
      sce_pkg::ST_PLAY: begin
        if (can_load) begin
          load = 1'b1;
          ld_kind = sce_pkg::KIND_CMD;
          ld_data = rd_data;
          ptr_next = ptr + sce_pkg::CNT_W'(1);
          state_next = (ptr_next == len) ? sce_pkg::ST_END : sce_pkg::ST_FETCH;
        end
      end
      sce_pkg::ST_END: begin
        if (can_load) begin
          load = 1'b1;
          ld_kind = sce_pkg::KIND_END;
          ld_last = 1'b1;
          state_next = sce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sce_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[q_head.cnt[sce_pkg::ADDR_W-1:0]] <= q_head.data;
    end
    rd_data <= line_mem[ptr[sce_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sce_pkg::ST_IDLE;
      ptr <= '0;
      len <= '0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      len <= len_next;
      if (load) begin
        o_valid <= 1'b1;
      end else if (!out_stall) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_kind <= ld_kind;
      o_data <= ld_data;
      o_last <= ld_last;
    end
  end

`include "serial_console_line_editor_unit_assert.svh"

`SCE_ASSERT_IMPLY(a_pop_when_idle, pop, state == sce_pkg::ST_IDLE, "command taken while busy")
`SCE_ASSERT_IMPLY(a_play_in_range, state == sce_pkg::ST_FETCH || state == sce_pkg::ST_PLAY, ptr < len, "playout pointer past line end")
`SCE_ASSERT_NEXT(a_erase_ends_last, state == sce_pkg::ST_ERASE2 && can_load, o_valid && o_last, "erase sequence did not end with a last result")

endmodule

### rtl/core/serial_console_line_editor_unit.sv
// ----------------------------------------------------------------------------
// Serial console line editor
// A command from an input transfer is queued; the back end then loads the
// result register from the queue head. The front takes one byte a cycle into
// a two-entry command queue while it is not full; the back end takes a command
// only when idle and plays a newline's stored bytes through the registered
// line store read. Reset clears line fill, escape state and queue.
// ----------------------------------------------------------------------------
module serial_console_line_editor_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       iterative_running,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] data_byte,
  output logic       run_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data
);

  sce_pkg::cfg_regs_t cfg;
  sce_pkg::cmd_t      push_cmd;
  sce_pkg::cmd_t      q_head;
  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.newline <= sce_pkg::RST_NEWLINE;
      cfg.erase <= sce_pkg::RST_ERASE;
      cfg.cursor_back <= sce_pkg::RST_CURSOR_BACK;
      cfg.blank <= sce_pkg::RST_BLANK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sce_pkg::CFG_NEWLINE:     cfg.newline <= cfg_data;
        sce_pkg::CFG_ERASE:       cfg.erase <= cfg_data;
        sce_pkg::CFG_CURSOR_BACK: cfg.cursor_back <= cfg_data;
        sce_pkg::CFG_BLANK:       cfg.blank <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sce_front u_front (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .rx_byte           (rx_byte),
    .iterative_running (iterative_running),
    .cfg               (cfg),
    .q_full            (q_full),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  sce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .pop      (pop)
  );

  sce_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .data_byte (data_byte),
    .run_last  (run_last)
  );

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// Serial console line editor testbench
// Sends terminal bytes under random bursts and output stalls and keeps its
// own copy of the line, the escape state and the registers. Every result
// transfer is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 16;
  localparam int PHASE_ITEMS = 42;
  localparam int PHASE_COUNT = 8;

  typedef struct packed {
    sce_pkg::kind_t kind;
    logic [7:0]     data;
    logic           is_last;
  } editor_out_t;

  class line_editor_mirror;
    logic [7:0]  line_bytes [sce_pkg::LINE_DEPTH];
    int unsigned fill;
    bit          escape_on;
    bit          bracket_on;
    logic [7:0]  newline_code;
    logic [7:0]  erase_code;
    logic [7:0]  cursor_back_code;
    logic [7:0]  blank_code;
    editor_out_t expected_outputs [$];
    editor_out_t fresh [$];
    int unsigned mismatches;

    function new();
      fill = 0;
      escape_on = 1'b0;
      bracket_on = 1'b0;
      newline_code = sce_pkg::RST_NEWLINE;
      erase_code = sce_pkg::RST_ERASE;
      cursor_back_code = sce_pkg::RST_CURSOR_BACK;
      blank_code = sce_pkg::RST_BLANK;
      mismatches = 0;
    endfunction

    function void set_reg(logic [7:0] idx, logic [7:0] val);
      case (idx)
        sce_pkg::CFG_NEWLINE: newline_code = val;
        sce_pkg::CFG_ERASE: erase_code = val;
        sce_pkg::CFG_CURSOR_BACK: cursor_back_code = val;
        sce_pkg::CFG_BLANK: blank_code = val;
        default: ;
      endcase
    endfunction

    function void emit(sce_pkg::kind_t k, logic [7:0] d);
      editor_out_t r;
      r.kind = k;
      r.data = d;
      r.is_last = 1'b0;
      fresh.push_back(r);
    endfunction

    function int take_rx_byte(logic [7:0] c, logic running);
      int n;
      fresh.delete();
      if (escape_on && !bracket_on && c != sce_pkg::BRACKET_BYTE) begin
        escape_on = 1'b0;
        bracket_on = 1'b0;
      end
      if (escape_on && bracket_on && c != sce_pkg::UP_BYTE && c != sce_pkg::DOWN_BYTE) begin
        escape_on = 1'b0;
        bracket_on = 1'b0;
      end
      if (fill >= sce_pkg::LINE_DEPTH - 1 && c != erase_code) begin
        emit(sce_pkg::KIND_FULL, 8'h00);
      end else if (c == newline_code) begin
        for (int i = 0; i < fill; i++) emit(sce_pkg::KIND_CMD, line_bytes[i]);
        emit(sce_pkg::KIND_END, 8'h00);
        fill = 0;
      end else if (c == erase_code) begin
        if (fill > 0) begin
          fill--;
          emit(sce_pkg::KIND_ECHO, cursor_back_code);
          emit(sce_pkg::KIND_ECHO, blank_code);
          emit(sce_pkg::KIND_ECHO, cursor_back_code);
        end
      end else if (c == sce_pkg::BREAK_BYTE) begin
        if (running) emit(sce_pkg::KIND_CANCEL, 8'h00);
      end else if (c == sce_pkg::ESC_BYTE) begin
        escape_on = 1'b1;
      end else if (escape_on && c == sce_pkg::BRACKET_BYTE) begin
        bracket_on = 1'b1;
      end else if (escape_on && bracket_on) begin
        if (c == sce_pkg::UP_BYTE) begin
          emit(sce_pkg::KIND_UP, 8'h00);
        end else begin
          emit(sce_pkg::KIND_DOWN, 8'h00);
        end
        escape_on = 1'b0;
        bracket_on = 1'b0;
      end else begin
        if (fill < sce_pkg::LINE_DEPTH) begin
          line_bytes[fill] = c;
          fill++;
        end
        emit(sce_pkg::KIND_ECHO, c);
      end
      n = fresh.size();
      if (n > 0) fresh[n-1].is_last = 1'b1;
      foreach (fresh[i]) expected_outputs.push_back(fresh[i]);
      return n;
    endfunction

    function void match_output(logic [2:0] k, logic [7:0] d, logic l);
      editor_out_t want;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: kind %0d data_byte 0x%02h run_last %0b", k, d, l);
        mismatches++;
        return;
      end
      want = expected_outputs.pop_front();
      if (k !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, k);
        mismatches++;
      end
      if (d !== want.data) begin
        $error("data_byte: expected 0x%02h, actual 0x%02h", want.data, d);
        mismatches++;
      end
      if (l !== want.is_last) begin
        $error("run_last: expected %0b, actual %0b", want.is_last, l);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_outputs.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] rx_byte;
  logic       iterative_running;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       run_last;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_index;
  logic [7:0] cfg_data;

  line_editor_mirror mirror;
  int unsigned       burst_left;
  int unsigned       echoed_items;

  serial_console_line_editor_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .iterative_running(iterative_running),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .data_byte(data_byte),
    .run_last(run_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL serial_console_line_editor_unit");
    $finish;
  end

  initial begin
    int mode;
    int left;
    int tick;
    mode = 0;
    left = 0;
    tick = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 120);
      end
      left--;
      tick++;
      case (mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (tick % 4 != 0);
        default: out_stall <= coin();
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) mirror.match_output(kind, data_byte, run_last);
  end

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 3) == 0) return any_byte();
    return 8'($urandom_range(32, 126));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic running);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    rx_byte <= b;
    iterative_running <= running;
    do @(posedge clk); while (in_stall);
    if (mirror.take_rx_byte(b, running) > 0) echoed_items++;
  endtask

  task automatic settle(input int extra);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (mirror.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    mirror.set_reg(idx, val);
  endtask

  task automatic program_regs(input logic [7:0] nl, input logic [7:0] er,
                              input logic [7:0] cb, input logic [7:0] bl);
    write_reg(sce_pkg::CFG_NEWLINE, nl);
    write_reg(sce_pkg::CFG_ERASE, er);
    write_reg(sce_pkg::CFG_CURSOR_BACK, cb);
    write_reg(sce_pkg::CFG_BLANK, bl);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_sequence();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        n = $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            send_byte(mirror.erase_code, coin());
          end else begin
            send_byte(text_byte(), coin());
          end
        end
        send_byte(mirror.newline_code, coin());
      end
      4: begin
        n = $urandom_range(sce_pkg::LINE_DEPTH - 1, sce_pkg::LINE_DEPTH + 4);
        repeat (n) send_byte(text_byte(), coin());
        n = $urandom_range(0, 2);
        repeat (n) send_byte(mirror.erase_code, coin());
        send_byte(mirror.newline_code, coin());
        send_byte(mirror.erase_code, coin());
        send_byte(mirror.newline_code, coin());
      end
      5, 6: begin
        send_byte(sce_pkg::ESC_BYTE, coin());
        send_byte(sce_pkg::BRACKET_BYTE, coin());
        send_byte(coin() ? sce_pkg::UP_BYTE : sce_pkg::DOWN_BYTE, coin());
      end
      7: begin
        send_byte(sce_pkg::ESC_BYTE, coin());
        if (coin()) send_byte(sce_pkg::BRACKET_BYTE, coin());
        send_byte(any_byte(), coin());
      end
      8: send_byte(sce_pkg::BREAK_BYTE, coin());
      default: begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(any_byte(), coin());
      end
    endcase
  endtask

  initial begin
    int goal;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    iterative_running = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = 8'h00;
    cfg_data = 8'h00;
    burst_left = 0;
    echoed_items = 0;
    mirror = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Stored bytes at both ends of the range, erase and newline, then erase on
    // an empty line and break with and without a running command.
    send_byte(8'h68, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(sce_pkg::RST_ERASE, 1'b1);
    send_byte(sce_pkg::RST_ERASE, 1'b0);
    send_byte(sce_pkg::RST_NEWLINE, 1'b0);
    send_byte(sce_pkg::RST_ERASE, 1'b0);
    send_byte(sce_pkg::BREAK_BYTE, 1'b0);
    send_byte(sce_pkg::BREAK_BYTE, 1'b1);
    // Both arrows, an aborted sequence after the bracket, an aborted sequence
    // after escape alone and a repeated escape.
    send_byte(sce_pkg::ESC_BYTE, 1'b0);
    send_byte(sce_pkg::BRACKET_BYTE, 1'b0);
    send_byte(sce_pkg::UP_BYTE, 1'b0);
    send_byte(sce_pkg::ESC_BYTE, 1'b1);
    send_byte(sce_pkg::BRACKET_BYTE, 1'b1);
    send_byte(sce_pkg::DOWN_BYTE, 1'b1);
    send_byte(sce_pkg::ESC_BYTE, 1'b0);
    send_byte(sce_pkg::BRACKET_BYTE, 1'b0);
    send_byte(8'h43, 1'b0);
    send_byte(sce_pkg::ESC_BYTE, 1'b0);
    send_byte(8'h58, 1'b1);
    send_byte(sce_pkg::ESC_BYTE, 1'b0);
    send_byte(sce_pkg::ESC_BYTE, 1'b0);
    send_byte(sce_pkg::BRACKET_BYTE, 1'b0);
    send_byte(sce_pkg::UP_BYTE, 1'b0);
    send_byte(sce_pkg::RST_NEWLINE, 1'b1);

    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase > 0) begin
        settle(SETTLE_CYCLES);
        case (phase)
          1: program_regs(8'd10, 8'd127, 8'd8, 8'd32);
          2: program_regs(8'd0, 8'd255, 8'd0, 8'd255);
          3: program_regs(8'd255, 8'd0, 8'd255, 8'd0);
          4: program_regs(sce_pkg::BRACKET_BYTE, sce_pkg::UP_BYTE, sce_pkg::ESC_BYTE,
                          sce_pkg::BREAK_BYTE);
          5: program_regs(sce_pkg::BREAK_BYTE, sce_pkg::BREAK_BYTE, any_byte(),
                          any_byte());
          6: program_regs(any_byte(), any_byte(), any_byte(), any_byte());
          default: program_regs(sce_pkg::RST_NEWLINE, sce_pkg::RST_ERASE,
                                sce_pkg::RST_CURSOR_BACK, sce_pkg::RST_BLANK);
        endcase
      end
      goal = echoed_items + PHASE_ITEMS;
      while (echoed_items < goal) random_sequence();
    end

    settle(TAIL_CYCLES);
    if (mirror.mismatches == 0) begin
      $display("PASS serial_console_line_editor_unit");
    end else begin
      $display("FAIL serial_console_line_editor_unit");
    end
    $finish;
  end

endmodule
